@@ hw/rtl/itp_pkg.sv @@
// itp_pkg: shared widths, register indexes, opcodes and controller/datapath
// interface structs for the isometric tile picker. No dependencies.
package itp_pkg;

    // Pixel coordinate width (signed two's complement).
    localparam int COORD_BITS = 16;

    // Configuration register widths and indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TSIZE_W    = 10;
    localparam int MAP_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_WIDTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_WIDTH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_HEIGHT  = 3'd4;

    localparam logic [TSIZE_W-1:0] RST_TILE_WIDTH  = 10'd64;
    localparam logic [TSIZE_W-1:0] RST_TILE_HEIGHT = 10'd32;
    localparam logic [MAP_W-1:0]   RST_MAP_WIDTH   = 16'd3200;
    localparam logic [MAP_W-1:0]   RST_MAP_HEIGHT  = 16'd1600;

    // Datapath widths.
    localparam int PROD_W = 2 * MAP_W;                 // one 16x16 product
    localparam int SUM_W  = PROD_W + 3;                // signed sums up to 3*H*W
    localparam int DVD_W  = SUM_W - 1;                 // non-negative dividend
    localparam int DVSR_W = TSIZE_W + MAP_W + 1;       // 2 * tile_height * map_width
    localparam int TILE_W = 17;                        // tile index output width
    localparam int Q_W    = TILE_W;                    // quotient bits per division
    localparam int DSH_W  = DVSR_W + Q_W - 1;          // aligned divisor width
    localparam int CNT_W  = $clog2(Q_W);
    localparam int RNG_W  = ((COORD_BITS > MAP_W) ? COORD_BITS : MAP_W) + 1;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * TILE_W + 7) / 8) * 8;

    localparam logic [TILE_W-1:0] TILE_SAT = 17'h0FFFF;

    // Multiplier operand selects, issued in this order.
    localparam int MUL_SEL_W = 3;
    localparam logic [MUL_SEL_W-1:0] MUL_YW   = 3'd0;   // y * W
    localparam logic [MUL_SEL_W-1:0] MUL_HX   = 3'd1;   // H * x
    localparam logic [MUL_SEL_W-1:0] MUL_HHW  = 3'd2;   // floor(H/2) * W
    localparam logic [MUL_SEL_W-1:0] MUL_HW   = 3'd3;   // H * W
    localparam logic [MUL_SEL_W-1:0] MUL_STEP = 3'd4;   // tile_height * W

    // Division axis select.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic                 capture;   // take a new pixel
        logic                 mul_en;    // run one product
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 eval;      // range/region test, load dividends
        logic                 div_load;  // start a division
        logic                 div_sel;   // axis of the division being started
        logic                 div_step;  // one quotient bit
        logic                 out_load;  // move result into the output register
    } itp_cmd_t;

    typedef struct packed {
        logic diamond;                   // grid mode is the diamond grid
    } itp_sts_t;

endpackage

@@ hw/rtl/itp_div.sv @@
// itp_div: restoring serial divider, one quotient bit per step.
// Depends on itp_pkg for widths.
module itp_div
    import itp_pkg::*;
(
    input  logic              aclk,
    input  logic              load,
    input  logic              step,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic [Q_W-1:0]    quotient
);

    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [DSH_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             fits;

    // The quotient is known to stay below 2**Q_W, so the divisor starts
    // aligned to the top quotient bit.
    assign fits = DSH_W'(rem_reg) >= dsh_reg;

    always_comb begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        if (load) begin
            rem_next = dividend;
            dsh_next = DSH_W'(divisor) << (Q_W - 1);
            q_next   = '0;
        end else if (step) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg[DVD_W-1:0];
            end
            q_next   = {q_reg[Q_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;

endmodule

@@ hw/rtl/itp_ctrl.sv @@
// itp_ctrl: sequencing state machine for the tile picker, plus the output
// valid flag. Depends on itp_pkg for the command and status structs.
module itp_ctrl
    import itp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  itp_sts_t sts,
    output itp_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_DX_LD  = 3'd3;
    localparam logic [2:0] S_DX_RUN = 3'd4;
    localparam logic [2:0] S_DY_LD  = 3'd5;
    localparam logic [2:0] S_DY_RUN = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             cnt_last_div;

    assign cnt_last_div = (cnt_reg == CNT_W'(Q_W - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.diamond ? S_MUL : S_EVAL;
                end
            end
            S_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cnt_reg[MUL_SEL_W-1:0];
                if (cnt_reg[MUL_SEL_W-1:0] == MUL_STEP) begin
                    cnt_next   = '0;
                    state_next = S_EVAL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_DX_LD;
            end
            S_DX_LD: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = AXIS_X;
                cnt_next     = '0;
                state_next   = S_DX_RUN;
            end
            S_DX_RUN: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last_div) begin
                    state_next = S_DY_LD;
                end
            end
            S_DY_LD: begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = AXIS_Y;
                cnt_next     = '0;
                state_next   = S_DY_RUN;
            end
            S_DY_RUN: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last_div) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/itp_dpath.sv @@
// itp_dpath: configuration registers, shared multiplier, region test,
// serial divider and output payload registers. Depends on itp_pkg, itp_div.
module itp_dpath
    import itp_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  itp_cmd_t                     cmd,
    output itp_sts_t                     sts,
    input  logic signed [COORD_BITS-1:0] pixel_x,
    input  logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         inside_res,
    output logic [TILE_W-1:0]            tile_x,
    output logic [TILE_W-1:0]            tile_y
);

    // Configuration.
    logic               grid_mode_reg;
    logic [TSIZE_W-1:0] tile_w_reg, tile_h_reg;
    logic [MAP_W-1:0]   map_w_reg, map_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_mode_reg <= 1'b1;
            tile_w_reg    <= RST_TILE_WIDTH;
            tile_h_reg    <= RST_TILE_HEIGHT;
            map_w_reg     <= RST_MAP_WIDTH;
            map_h_reg     <= RST_MAP_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GRID_MODE:   grid_mode_reg <= cfg_wdata[0];
                REG_TILE_WIDTH:  tile_w_reg    <= cfg_wdata[TSIZE_W-1:0];
                REG_TILE_HEIGHT: tile_h_reg    <= cfg_wdata[TSIZE_W-1:0];
                REG_MAP_WIDTH:   map_w_reg     <= cfg_wdata[MAP_W-1:0];
                REG_MAP_HEIGHT:  map_h_reg     <= cfg_wdata[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign sts.diamond = grid_mode_reg;

    logic [TSIZE_W-1:0] tw_eff, th_eff;
    assign tw_eff = (tile_w_reg == '0) ? TSIZE_W'(1) : tile_w_reg;
    assign th_eff = (tile_h_reg == '0) ? TSIZE_W'(1) : tile_h_reg;

    // Captured pixel.
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [MAP_W-1:0]             x_u, y_u;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= pixel_x;
            y_reg <= pixel_y;
        end
    end

    // Only used when the pixel is in range, where it is non-negative and fits.
    assign x_u = MAP_W'(x_reg);
    assign y_u = MAP_W'(y_reg);

    // Shared multiplier: one product per cycle into its own register.
    logic [MAP_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] p_yw_reg, p_hx_reg, p_hhw_reg, p_hw_reg, p_step_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_YW:  begin mul_a = y_u;                mul_b = map_w_reg; end
            MUL_HX:  begin mul_a = map_h_reg;          mul_b = x_u;       end
            MUL_HHW: begin mul_a = map_h_reg >> 1;     mul_b = map_w_reg; end
            MUL_HW:  begin mul_a = map_h_reg;          mul_b = map_w_reg; end
            default: begin mul_a = MAP_W'(th_eff);     mul_b = map_w_reg; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                MUL_YW:  p_yw_reg   <= mul_p;
                MUL_HX:  p_hx_reg   <= mul_p;
                MUL_HHW: p_hhw_reg  <= mul_p;
                MUL_HW:  p_hw_reg   <= mul_p;
                default: p_step_reg <= mul_p;
            endcase
        end
    end

    // Range and region test.
    logic             in_range, left_half, in_region, inside_now;
    logic [SUM_W-1:0] yw, hx, hhw, hw;
    logic [SUM_W-1:0] dy_m1, dx_m1;

    assign in_range = !x_reg[COORD_BITS-1] && !y_reg[COORD_BITS-1]
                    && (RNG_W'($unsigned(x_reg)) <= RNG_W'(map_w_reg))
                    && (RNG_W'($unsigned(y_reg)) <= RNG_W'(map_h_reg));

    assign yw  = SUM_W'(p_yw_reg);
    assign hx  = SUM_W'(p_hx_reg);
    assign hhw = SUM_W'(p_hhw_reg);
    assign hw  = SUM_W'(p_hw_reg);

    assign left_half = ({1'b0, x_u, 1'b0} <= {2'b00, map_w_reg});

    always_comb begin
        if (left_half) begin
            in_region = (yw + hx >= hhw) && (yw <= hx + hhw);
        end else begin
            in_region = (yw + hhw >= hx) && (((yw + hx) << 1) <= hw + (hw << 1));
        end
    end

    // D - 1 for both counts; -a - 1 is written as ~a.
    assign dy_m1 = (yw << 1) + hw + ~(hx << 1);
    assign dx_m1 = (yw << 1) + (hx << 1) + ~hw;

    assign inside_now = in_range && (!grid_mode_reg || ((map_w_reg != '0) && in_region));

    // Division operands, one set per axis.
    logic              inside_reg;
    logic              pos_x_reg, pos_y_reg;
    logic [DVD_W-1:0]  dvd_x_reg, dvd_y_reg;
    logic [DVSR_W-1:0] dvsr_x_reg, dvsr_y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            inside_reg <= inside_now;
            if (grid_mode_reg) begin
                pos_x_reg  <= !dx_m1[SUM_W-1];
                pos_y_reg  <= !dy_m1[SUM_W-1];
                dvd_x_reg  <= dx_m1[SUM_W-1] ? '0 : dx_m1[DVD_W-1:0];
                dvd_y_reg  <= dy_m1[SUM_W-1] ? '0 : dy_m1[DVD_W-1:0];
                dvsr_x_reg <= DVSR_W'({p_step_reg, 1'b0});
                dvsr_y_reg <= DVSR_W'({p_step_reg, 1'b0});
            end else begin
                pos_x_reg  <= 1'b1;
                pos_y_reg  <= 1'b1;
                dvd_x_reg  <= DVD_W'(x_u);
                dvd_y_reg  <= DVD_W'(y_u);
                dvsr_x_reg <= DVSR_W'(tw_eff);
                dvsr_y_reg <= DVSR_W'(th_eff);
            end
        end
    end

    logic [DVD_W-1:0]  div_dvd;
    logic [DVSR_W-1:0] div_dvsr;
    logic [Q_W-1:0]    div_q;

    assign div_dvd  = (cmd.div_sel == AXIS_Y) ? dvd_y_reg  : dvd_x_reg;
    assign div_dvsr = (cmd.div_sel == AXIS_Y) ? dvsr_y_reg : dvsr_x_reg;

    itp_div u_div (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (div_dvd),
        .divisor  (div_dvsr),
        .quotient (div_q)
    );

    // A non-positive offset gives -1, a large count saturates.
    logic [TILE_W-1:0] q_sat, tx_val_reg;

    assign q_sat = div_q[Q_W-1] ? TILE_SAT : div_q;

    // The x quotient is done when the y division starts.
    always_ff @(posedge aclk) begin
        if (cmd.div_load && (cmd.div_sel == AXIS_Y)) begin
            tx_val_reg <= pos_x_reg ? q_sat : '1;
        end
    end

    // Output payload register.
    logic              out_inside_reg;
    logic [TILE_W-1:0] out_tx_reg, out_ty_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_inside_reg <= inside_reg;
            out_tx_reg     <= inside_reg ? tx_val_reg : '0;
            out_ty_reg     <= inside_reg ? (pos_y_reg ? q_sat : '1) : '0;
        end
    end

    assign inside_res = out_inside_reg;
    assign tile_x     = out_tx_reg;
    assign tile_y     = out_ty_reg;

endmodule

@@ hw/rtl/iso_tile_pick_top.sv @@
// iso_tile_pick_top: top level of the isometric tile picker.
// Depends on itp_pkg, itp_ctrl, itp_dpath (which holds itp_div).
//
//  channel | direction | words                        | handshake
//  --------+-----------+------------------------------+--------------------
//  s_      | in        | one pixel (x, y)             | tvalid & tready
//  m_      | out       | one tile result per pixel    | tvalid & tready
//  cfg_    | in        | register write (index, data) | cfg_wr_en, no wait
//
// Between acceptance and a loaded result a pixel makes five passes through the
// single 16x16 multiplier (diamond only), a range and region test, and two
// 17-step runs of the serial divider, one per tile axis. Most of the time goes
// to the divider.
// One pixel is in work at a time; a new one is taken as soon as the previous
// result has moved into the output register, even if that word is not yet taken.
// Reset is synchronous and active low; it returns the configuration registers
// to their defaults, the state machine to idle and clears the output valid
// flag. A stalled output only holds the finished pixel in its last state
// until the output register frees up.
module iso_tile_pick_top
    import itp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Pixel input. s_tdata: pixel_x [15:0], pixel_y [31:16].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Tile output. m_tdata: tile_x [16:0], tile_y [33:17], zero padding above.
    // m_tuser: inside_res [0].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,
    // Register writes, index in the order grid_mode, tile_width,
    // tile_height, map_width, map_height.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    itp_cmd_t cmd;
    itp_sts_t sts;

    logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
    logic [TILE_W-1:0]            tile_x, tile_y;

    // Unpack the incoming word.
    assign pixel_x = s_tdata[COORD_BITS-1:0];
    assign pixel_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    // The controller owns the handshakes and the output valid flag.
    itp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns configuration, arithmetic and the output payload.
    itp_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .sts        (sts),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .inside_res (m_tuser),
        .tile_x     (tile_x),
        .tile_y     (tile_y)
    );

    // Pack the result word; padding bits are zero.
    assign m_tdata = M_TDATA_W'({tile_y, tile_x});

endmodule
